// ===== src/dpcf_pkg.sv =====
// ----------------------------------------------------------------------------
// dpcf_pkg
// Shared types and constants for the debounced palette colour fader.
// ----------------------------------------------------------------------------
package dpcf_pkg;

    localparam int CHAN_W    = 8;
    localparam int RGB_W     = 3 * CHAN_W;
    localparam int SLOT_W    = 3;
    localparam int PAL_DEPTH = 8;
    localparam int HOLD_W    = 10;
    localparam int GAP_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 10;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_GAP       = 1'd1;

    // Register reset values
    localparam logic [HOLD_W-1:0] DEBOUNCE_TICKS_RST = 10'd60;
    localparam logic [GAP_W-1:0]  FADE_GAP_RST       = 8'd3;
    localparam logic [HOLD_W-1:0] HOLD_MAX           = '1;

    // Reset state of the colour path
    localparam logic [SLOT_W-1:0] SLOT_RST    = 3'd1;
    localparam logic [RGB_W-1:0]  TARGET_RST  = 24'h7FFFFF;
    localparam logic [RGB_W-1:0]  CURRENT_RST = 24'h010101;

    // Palette, red in the top byte
    localparam logic [RGB_W-1:0] PALETTE [PAL_DEPTH] = '{
        24'hFF0000, 24'h7FFFFF, 24'hFF3F00, 24'h00FF00,
        24'h0000FF, 24'hFF7F00, 24'hFF00FF, 24'hFFFFFF
    };

    // Slot and colour that this tick targets
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [RGB_W-1:0]  target;
    } slot_info_t;

endpackage

// ===== src/dpcf_debounce.sv =====
// ----------------------------------------------------------------------------
// dpcf_debounce
// Button debouncer and palette slot selector; advances the slot once per
// qualified press.
// ----------------------------------------------------------------------------
module dpcf_debounce #(
    parameter int PALETTE_SIZE = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic                          button,
    input  logic [dpcf_pkg::HOLD_W-1:0]   debounce_ticks,
    output dpcf_pkg::slot_info_t          info_next
);
    import dpcf_pkg::*;

    typedef enum logic [1:0] {
        PH_RELEASED,
        PH_QUALIFYING,
        PH_HELD
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [RGB_W-1:0]  target_reg, target_next;
    logic [SLOT_W-1:0] slot_inc;
    logic [HOLD_W-1:0] hold_inc;

    // Wrap the slot at the palette size and saturate the hold counter
    always_comb begin
        slot_inc = slot_reg + 1'b1;
        if (32'(slot_inc) >= PALETTE_SIZE) begin
            slot_inc = '0;
        end
        hold_inc = (hold_reg == HOLD_MAX) ? hold_reg : hold_reg + 1'b1;
    end

    // Debounce phases
    always_comb begin
        phase_next  = phase_reg;
        hold_next   = hold_reg;
        slot_next   = slot_reg;
        target_next = target_reg;
        if (accept) begin
            if (!button) begin
                phase_next = PH_RELEASED;
            end else begin
                unique case (phase_reg)
                    PH_RELEASED: begin
                        hold_next  = '0;
                        phase_next = PH_QUALIFYING;
                    end
                    PH_QUALIFYING: begin
                        hold_next = hold_inc;
                        if (hold_inc >= debounce_ticks) begin
                            slot_next   = slot_inc;
                            target_next = PALETTE[slot_inc];
                            phase_next  = PH_HELD;
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    assign info_next.slot   = slot_next;
    assign info_next.target = target_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_RELEASED;
            hold_reg   <= '0;
            slot_reg   <= SLOT_RST;
            target_reg <= TARGET_RST;
        end else begin
            phase_reg  <= phase_next;
            hold_reg   <= hold_next;
            slot_reg   <= slot_next;
            target_reg <= target_next;
        end
    end

    a_release_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !button) |=> (phase_reg == PH_RELEASED))
        else $error("release did not return the debouncer to released");

    a_slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(slot_reg) < PALETTE_SIZE))
        else $error("palette slot beyond palette size");

endmodule

// ===== src/dpcf_fader.sv =====
// ----------------------------------------------------------------------------
// dpcf_fader
// Fade interval counter, per-channel step toward the target and result
// register.
// ----------------------------------------------------------------------------
module dpcf_fader (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  logic [dpcf_pkg::GAP_W-1:0]      fade_gap,
    input  dpcf_pkg::slot_info_t            info_next,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [dpcf_pkg::M_DATA_W-1:0]   m_tdata
);
    import dpcf_pkg::*;

    logic [GAP_W-1:0]    elapsed_reg, elapsed_next;
    logic [GAP_W:0]      elapsed_inc;
    logic [RGB_W-1:0]    current_reg, current_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                step;

    // Move one channel a unit toward its target
    function automatic logic [CHAN_W-1:0] toward(input logic [CHAN_W-1:0] cur,
                                                 input logic [CHAN_W-1:0] tgt);
        logic [CHAN_W-1:0] res;
        res = cur;
        if (cur < tgt) begin
            res = cur + 1'b1;
        end else if (cur > tgt) begin
            res = cur - 1'b1;
        end
        return res;
    endfunction

    assign elapsed_inc = {1'b0, elapsed_reg} + 1'b1;
    assign step        = accept && (elapsed_inc > {1'b0, fade_gap});

    // Count ticks and step the colour
    always_comb begin
        elapsed_next = elapsed_reg;
        current_next = current_reg;
        if (accept) begin
            elapsed_next = step ? '0 : elapsed_inc[GAP_W-1:0];
        end
        if (step) begin
            for (int c = 0; c < 3; c++) begin
                current_next[c*CHAN_W +: CHAN_W] =
                    toward(current_reg[c*CHAN_W +: CHAN_W],
                           info_next.target[c*CHAN_W +: CHAN_W]);
            end
        end
    end

    // Load a result, or drop it once taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (step) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {5'd0, info_next.slot,
                             current_next[7:0], current_next[15:8], current_next[23:16]};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg  <= '0;
            current_reg  <= CURRENT_RST;
            m_tvalid_reg <= 1'b0;
        end else begin
            elapsed_reg  <= elapsed_next;
            current_reg  <= current_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_step_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> (m_tvalid_reg && (m_tdata_reg[23:0] ==
                  {current_reg[7:0], current_reg[15:8], current_reg[23:16]})))
        else $error("fade step did not load the result register");

    a_colour_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$past(step)) |-> $stable(current_reg))
        else $error("colour changed without a fade step");

endmodule

// ===== src/debounced_palette_color_fader_core.sv =====
// ----------------------------------------------------------------------------
// debounced_palette_color_fader_core
// Debounced button steps through a fixed colour palette; the output colour
// fades one unit per channel toward the selected entry.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/tready    s_tdata[0] button_pressed
//  m_       out  m_tvalid/tready    red, green, blue, palette_slot
//  cfg_     in   cfg_wr_en          cfg_index, cfg_wdata
//
//  One tick transaction is accepted per cycle while s_tready is high; state updates at that edge.
//  A fade step's result is in m_tdata the cycle after its tick is accepted.
//  s_tready falls only while an untaken result sits in the output register
//  and m_tready is low.
//  aresetn is synchronous, active low; registers return to 60 and 3.
// ----------------------------------------------------------------------------
module debounced_palette_color_fader_core #(
    parameter int PALETTE_SIZE = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dpcf_pkg::S_DATA_W-1:0]     s_tdata,   // [0] button_pressed
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dpcf_pkg::M_DATA_W-1:0]     m_tdata,   // [7:0] red, [15:8] green,
                                                         // [23:16] blue,
                                                         // [26:24] palette_slot
    input  logic                              cfg_wr_en,
    input  logic [dpcf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dpcf_pkg::CFG_DAT_W-1:0]    cfg_wdata
);
    import dpcf_pkg::*;

    logic [HOLD_W-1:0] debounce_ticks_reg, debounce_ticks_next;
    logic [GAP_W-1:0]  fade_gap_reg, fade_gap_next;
    logic              accept;
    slot_info_t        info_next;

    // Configuration writes
    always_comb begin
        debounce_ticks_next = debounce_ticks_reg;
        fade_gap_next       = fade_gap_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DEBOUNCE_TICKS: debounce_ticks_next = cfg_wdata[HOLD_W-1:0];
                REG_FADE_GAP:       fade_gap_next       = cfg_wdata[GAP_W-1:0];
                default:            fade_gap_next       = fade_gap_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg <= DEBOUNCE_TICKS_RST;
            fade_gap_reg       <= FADE_GAP_RST;
        end else begin
            debounce_ticks_reg <= debounce_ticks_next;
            fade_gap_reg       <= fade_gap_next;
        end
    end

    // Accept whenever the result register is free or being emptied
    assign s_tready = !m_tvalid || m_tready;
    assign accept   = s_tvalid && s_tready;

    dpcf_debounce #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_debounce (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .button         (s_tdata[0]),
        .debounce_ticks (debounce_ticks_reg),
        .info_next      (info_next)
    );

    dpcf_fader u_fader (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .fade_gap  (fade_gap_reg),
        .info_next (info_next),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule
